@@ hdl/lhr_pkg.sv @@
package lhr_pkg;

   localparam int LENGTH_BITS    = 24;
   localparam int WORD_BITS      = 32;
   localparam int ADDR_BITS      = 5;
   localparam int PACKET_COUNT   = 3;
   localparam int SERIAL_BYTES   = 3 * 4;
   localparam int HEADER_BYTES   = 2 * 4;
   localparam int FIFO_DEPTH     = 4;
   localparam int FIFO_PTR_BITS  = 2;

   localparam logic [7:0] LACE_CONTINUE = 8'd255;
   localparam logic [7:0] COUNT_BYTE    = 8'(PACKET_COUNT - 1);

   localparam logic [2:0] REG_PAYLOAD_LENGTH = 3'd0;
   localparam logic [2:0] REG_TRACK_UID      = 3'd1;
   localparam logic [2:0] REG_SERIAL_TAG     = 3'd2;
   localparam logic [2:0] REG_HEADER_TAG     = 3'd3;
   localparam logic [2:0] REG_COMMENT_TAG    = 3'd4;
   localparam logic [2:0] REG_CODEBOOK_TAG   = 3'd5;

   typedef enum logic [2:0] {
      PH_COUNT,
      PH_LACING,
      PH_DATA,
      PH_DONE,
      PH_ERROR
   } phase_type;

   typedef enum logic [2:0] {
      SEQ_START,
      SEQ_ERROR,
      SEQ_DATA,
      SEQ_SERIAL,
      SEQ_HEADER
   } seq_state_type;

   typedef struct packed {
      logic [LENGTH_BITS-1:0] payload_length;
      logic [WORD_BITS-1:0]   track_uid;
      logic [WORD_BITS-1:0]   serial_tag;
      logic [WORD_BITS-1:0]   header_tag;
      logic [WORD_BITS-1:0]   comment_tag;
      logic [WORD_BITS-1:0]   codebook_tag;
   } cfg_type;

   typedef struct packed {
      logic [LENGTH_BITS-1:0] size_first;
      logic [LENGTH_BITS-1:0] size_second;
      logic [LENGTH_BITS-1:0] size_third;
   } sizes_type;

   typedef struct packed {
      logic       is_error;
      logic       has_data;
      logic [7:0] data;
      logic       has_serial;
      logic [1:0] hdr_first;
      logic [1:0] hdr_count;
      logic       finish;
   } cmd_type;

endpackage

@@ hdl/lhr_csr.sv @@
module lhr_csr import lhr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [WORD_BITS-1:0] pwdata,
   output logic [WORD_BITS-1:0] prdata,
   output logic                 pready,
   output cfg_type              cfg
);

   localparam cfg_type CFG_RESET = '{
      payload_length: LENGTH_BITS'(1),
      track_uid:      '0,
      serial_tag:     '0,
      header_tag:     '0,
      comment_tag:    '0,
      codebook_tag:   '0
   };

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write_en;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (paddr[4:2])
            REG_PAYLOAD_LENGTH: cfg_in.payload_length = pwdata[LENGTH_BITS-1:0];
            REG_TRACK_UID:      cfg_in.track_uid      = pwdata;
            REG_SERIAL_TAG:     cfg_in.serial_tag     = pwdata;
            REG_HEADER_TAG:     cfg_in.header_tag     = pwdata;
            REG_COMMENT_TAG:    cfg_in.comment_tag    = pwdata;
            REG_CODEBOOK_TAG:   cfg_in.codebook_tag   = pwdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_PAYLOAD_LENGTH: prdata = WORD_BITS'(cfg_ff.payload_length);
         REG_TRACK_UID:      prdata = cfg_ff.track_uid;
         REG_SERIAL_TAG:     prdata = cfg_ff.serial_tag;
         REG_HEADER_TAG:     prdata = cfg_ff.header_tag;
         REG_COMMENT_TAG:    prdata = cfg_ff.comment_tag;
         REG_CODEBOOK_TAG:   prdata = cfg_ff.codebook_tag;
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hdl/lhr_front.sv @@
module lhr_front import lhr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       fifo_full,
   output logic       push,
   output cmd_type    push_cmd,
   output sizes_type  sizes
);

   typedef struct packed {
      logic [1:0] count;
      logic       finish;
      logic [1:0] last_k;
   } open_type;

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

   // Opens packets from k on: each one gets a header, and opening continues
   // past empty packets until a non-empty one or the end of the stream.
   function automatic open_type open_from(input logic [1:0] k, input logic [2:0] zero);
      open_type   r;
      logic       stop;
      logic [1:0] j;
      r.count  = 2'd0;
      r.finish = 1'b0;
      r.last_k = k;
      stop     = 1'b0;
      j        = k;
      for (int i = 0; i < PACKET_COUNT; i++) begin
         if (!stop && (int'(k) + i) < PACKET_COUNT) begin
            j        = 2'(int'(k) + i);
            r.count  = r.count + 2'd1;
            r.last_k = j;
            if (!zero[j]) begin
               stop = 1'b1;
            end else if (j == 2'(PACKET_COUNT - 1)) begin
               r.finish = 1'b1;
               stop     = 1'b1;
            end
         end
      end
      return r;
   endfunction

   function automatic logic [LENGTH_BITS-1:0] size_of(input logic [1:0] k, input sizes_type s);
      logic [LENGTH_BITS-1:0] r;
      case (k)
         2'd0:    r = s.size_first;
         2'd1:    r = s.size_second;
         default: r = s.size_third;
      endcase
      return r;
   endfunction

   phase_type              phase_ff, phase_in;
   logic [1:0]             pidx_ff, pidx_in;
   sizes_type              sizes_ff, sizes_in;
   logic [LENGTH_BITS-1:0] seen_ff, seen_in;
   logic [LENGTH_BITS-1:0] left_ff, left_in;

   logic                   take;
   logic [LENGTH_BITS:0]   pos_plus;
   logic                   at_end;
   logic [LENGTH_BITS-1:0] acc_old;
   logic [LENGTH_BITS:0]   acc_sum;
   logic [LENGTH_BITS-1:0] acc_sat;
   logic                   lace_low;
   logic                   close;
   logic [LENGTH_BITS+1:0] used;
   logic                   over;
   sizes_type              sizes_new;
   logic [LENGTH_BITS-1:0] left_dec;
   logic                   data_done;
   logic                   data_last_packet;
   open_type               open_close;
   open_type               open_data;
   logic                   err;
   logic                   finish_now;

   assign req_ready = !fifo_full;
   assign take      = req_valid && req_ready;
   assign sizes     = sizes_ff;

   always_comb begin
      pos_plus = {1'b0, seen_ff} + (LENGTH_BITS+1)'(1);
      at_end   = pos_plus >= {1'b0, cfg.payload_length};
      seen_in  = (seen_ff != LEN_MAX) ? pos_plus[LENGTH_BITS-1:0] : seen_ff;

      acc_old  = (pidx_ff == 2'd0) ? sizes_ff.size_first : sizes_ff.size_second;
      acc_sum  = {1'b0, acc_old} + (LENGTH_BITS+1)'(req_data_byte);
      acc_sat  = acc_sum[LENGTH_BITS] ? LEN_MAX : acc_sum[LENGTH_BITS-1:0];
      lace_low = req_data_byte != LACE_CONTINUE;
      close    = lace_low && (pidx_ff == 2'd1);

      sizes_new             = sizes_ff;
      if (pidx_ff == 2'd0) begin
         sizes_new.size_first = acc_sat;
      end else begin
         sizes_new.size_second = acc_sat;
      end
      used = {1'b0, pos_plus} + (LENGTH_BITS+2)'(sizes_new.size_first)
           + (LENGTH_BITS+2)'(sizes_new.size_second);
      over = used > (LENGTH_BITS+2)'(cfg.payload_length);
      sizes_new.size_third = cfg.payload_length - used[LENGTH_BITS-1:0];

      open_close = open_from(2'd0, {sizes_new.size_third == '0,
                                    sizes_new.size_second == '0,
                                    sizes_new.size_first == '0});
      open_data  = open_from(pidx_ff + 2'd1, {sizes_ff.size_third == '0,
                                              sizes_ff.size_second == '0,
                                              sizes_ff.size_first == '0});

      left_dec         = left_ff - LENGTH_BITS'(1);
      data_done        = left_dec == '0;
      data_last_packet = pidx_ff >= 2'(PACKET_COUNT - 1);
   end

   always_comb begin
      err        = 1'b0;
      finish_now = 1'b0;
      push       = 1'b0;
      push_cmd   = '0;
      sizes_in   = sizes_ff;
      pidx_in    = pidx_ff;
      left_in    = left_ff;
      push_cmd.data = req_data_byte;
      if (take) begin
         case (phase_ff)
            PH_COUNT: begin
               err     = (req_data_byte != COUNT_BYTE) || at_end;
               pidx_in = 2'd0;
            end
            PH_LACING: begin
               sizes_in.size_first  = sizes_new.size_first;
               sizes_in.size_second = sizes_new.size_second;
               if (close) begin
                  err = over;
                  if (!over) begin
                     sizes_in.size_third = sizes_new.size_third;
                     pidx_in             = open_close.last_k;
                     left_in             = size_of(open_close.last_k, sizes_new);
                     finish_now          = open_close.finish;
                     push                = 1'b1;
                     push_cmd.has_serial = 1'b1;
                     push_cmd.hdr_first  = 2'd0;
                     push_cmd.hdr_count  = open_close.count;
                     push_cmd.finish     = open_close.finish;
                  end
               end else begin
                  err = at_end;
                  if (lace_low) begin
                     pidx_in = pidx_ff + 2'd1;
                  end
               end
            end
            PH_DATA: begin
               push              = 1'b1;
               push_cmd.has_data = 1'b1;
               left_in           = left_dec;
               if (data_done) begin
                  if (data_last_packet) begin
                     finish_now      = 1'b1;
                     push_cmd.finish = 1'b1;
                  end else begin
                     pidx_in            = open_data.last_k;
                     left_in            = size_of(open_data.last_k, sizes_ff);
                     finish_now         = open_data.finish;
                     push_cmd.hdr_first = pidx_ff + 2'd1;
                     push_cmd.hdr_count = open_data.count;
                     push_cmd.finish    = open_data.finish;
                  end
               end
            end
            default: begin
               push = 1'b0;
            end
         endcase
         if (err) begin
            push              = 1'b1;
            push_cmd          = '0;
            push_cmd.is_error = 1'b1;
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         case (phase_ff)
            PH_COUNT:  phase_in = err ? PH_ERROR : PH_LACING;
            PH_LACING: begin
               if (err) begin
                  phase_in = PH_ERROR;
               end else if (close) begin
                  phase_in = finish_now ? PH_DONE : PH_DATA;
               end
            end
            PH_DATA:   phase_in = finish_now ? PH_DONE : PH_DATA;
            default:   phase_in = phase_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_COUNT;
         pidx_ff  <= 2'd0;
         sizes_ff <= '0;
         seen_ff  <= '0;
         left_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         pidx_ff  <= pidx_in;
         sizes_ff <= sizes_in;
         left_ff  <= left_in;
         if (take) begin
            seen_ff <= seen_in;
         end
      end
   end

endmodule

@@ hdl/lhr_fifo.sv @@
module lhr_fifo import lhr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type                  entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_BITS:0]   count_ff, count_in;
   logic                     do_push;
   logic                     do_pop;

   assign full       = count_ff == (FIFO_PTR_BITS+1)'(FIFO_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + FIFO_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + FIFO_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (FIFO_PTR_BITS+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (FIFO_PTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hdl/lhr_back.sv @@
module lhr_back import lhr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  sizes_type  sizes,
   input  logic       head_valid,
   input  cmd_type    head_cmd,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_error,
   output logic       rsp_run_last,
   output logic       rsp_stream_end
);

   localparam logic [3:0] SERIAL_LAST = 4'(SERIAL_BYTES - 1);
   localparam logic [3:0] HEADER_LAST = 4'(HEADER_BYTES - 1);

   seq_state_type state_ff, state_in;
   logic [3:0]    idx_ff, idx_in;
   logic [1:0]    k_ff, k_in;
   logic [1:0]    left_ff, left_in;

   logic          valid_ff, valid_in;
   logic [7:0]    byte_ff, byte_in;
   logic          error_ff, error_in;
   logic          last_ff, last_in;
   logic          end_ff, end_in;

   seq_state_type seg;
   logic [3:0]    idx;
   logic [1:0]    k;
   logic [1:0]    left;
   logic          emit;
   logic          cmd_last;
   logic [WORD_BITS-1:0] word;
   logic [LENGTH_BITS-1:0] size_k;
   logic [WORD_BITS-1:0] tag_k;

   assign emit           = head_valid && (!valid_ff || rsp_ready);
   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_is_error   = error_ff;
   assign rsp_run_last   = last_ff;
   assign rsp_stream_end = end_ff;

   always_comb begin
      if (state_ff == SEQ_START) begin
         if (head_cmd.is_error) begin
            seg = SEQ_ERROR;
         end else if (head_cmd.has_data) begin
            seg = SEQ_DATA;
         end else if (head_cmd.has_serial) begin
            seg = SEQ_SERIAL;
         end else begin
            seg = SEQ_HEADER;
         end
         idx  = 4'd0;
         k    = head_cmd.hdr_first;
         left = head_cmd.hdr_count;
      end else begin
         seg  = state_ff;
         idx  = idx_ff;
         k    = k_ff;
         left = left_ff;
      end
   end

   // Next position within the word sequence of the command at the queue head.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      k_in     = k_ff;
      left_in  = left_ff;
      cmd_last = 1'b0;
      case (seg)
         SEQ_ERROR: cmd_last = 1'b1;
         SEQ_DATA: begin
            idx_in  = 4'd0;
            k_in    = head_cmd.hdr_first;
            left_in = head_cmd.hdr_count;
            if (head_cmd.has_serial) begin
               state_in = SEQ_SERIAL;
            end else if (head_cmd.hdr_count != 2'd0) begin
               state_in = SEQ_HEADER;
            end else begin
               cmd_last = 1'b1;
            end
         end
         SEQ_SERIAL: begin
            if (idx == SERIAL_LAST) begin
               state_in = SEQ_HEADER;
               idx_in   = 4'd0;
               k_in     = head_cmd.hdr_first;
               left_in  = head_cmd.hdr_count;
            end else begin
               state_in = SEQ_SERIAL;
               idx_in   = idx + 4'd1;
            end
         end
         SEQ_HEADER: begin
            state_in = SEQ_HEADER;
            k_in     = k;
            left_in  = left;
            if (idx == HEADER_LAST) begin
               if (left == 2'd1) begin
                  cmd_last = 1'b1;
               end else begin
                  idx_in  = 4'd0;
                  k_in    = k + 2'd1;
                  left_in = left - 2'd1;
               end
            end else begin
               idx_in = idx + 4'd1;
            end
         end
         default: cmd_last = 1'b1;
      endcase
      if (cmd_last) begin
         state_in = SEQ_START;
      end
   end

   always_comb begin
      case (k)
         2'd0: begin
            size_k = sizes.size_first;
            tag_k  = cfg.header_tag;
         end
         2'd1: begin
            size_k = sizes.size_second;
            tag_k  = cfg.comment_tag;
         end
         default: begin
            size_k = sizes.size_third;
            tag_k  = cfg.codebook_tag;
         end
      endcase
   end

   always_comb begin
      word     = '0;
      byte_in  = 8'd0;
      error_in = 1'b0;
      case (seg)
         SEQ_ERROR: error_in = 1'b1;
         SEQ_DATA:  byte_in  = head_cmd.data;
         SEQ_SERIAL: begin
            case (idx[3:2])
               2'd0:    word = WORD_BITS'(SERIAL_BYTES);
               2'd1:    word = cfg.serial_tag;
               default: word = cfg.track_uid;
            endcase
         end
         SEQ_HEADER: begin
            word = idx[2] ? tag_k : (WORD_BITS'(size_k) + WORD_BITS'(HEADER_BYTES));
         end
         default: byte_in = 8'd0;
      endcase
      if (seg == SEQ_SERIAL || seg == SEQ_HEADER) begin
         case (idx[1:0])
            2'd0:    byte_in = word[31:24];
            2'd1:    byte_in = word[23:16];
            2'd2:    byte_in = word[15:8];
            default: byte_in = word[7:0];
         endcase
      end
      last_in  = cmd_last;
      end_in   = cmd_last && (head_cmd.is_error || head_cmd.finish);
      pop      = emit && cmd_last;
      valid_in = emit || (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff  <= byte_in;
         error_ff <= error_in;
         last_ff  <= last_in;
         end_ff   <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_START;
         idx_ff   <= 4'd0;
         k_ff     <= 2'd0;
         left_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (emit) begin
            state_ff <= state_in;
            idx_ff   <= idx_in;
            k_ff     <= k_in;
            left_ff  <= left_in;
         end
      end
   end

endmodule

@@ hdl/xiph_lacing_header_repacker.sv @@
// Channel   Direction  Handshake              Word
// req       in         req_valid/req_ready    req_data_byte
// rsp       out        rsp_valid/rsp_ready    rsp_out_byte, rsp_is_error, rsp_run_last,
//                                             rsp_stream_end
// csr       in         psel/penable/pready    paddr, pwdata, prdata
//
// One input word is taken per cycle while the four-entry command queue has room.
// The output sequencer sends one word per cycle when not stalled by rsp_ready;
// one input word can cause up to 36 output words (when lacing closes).
// Reset is synchronous and active high; no clearing pass is needed after it.
// Either side may stall on its own; the queue and output register absorb the slip.
module xiph_lacing_header_repacker import lhr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_is_error,
   output logic                 rsp_run_last,
   output logic                 rsp_stream_end,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [WORD_BITS-1:0] pwdata,
   output logic [WORD_BITS-1:0] prdata,
   output logic                 pready
);

   cfg_type   cfg;
   sizes_type sizes;
   logic      fifo_full;
   logic      push;
   cmd_type   push_cmd;
   logic      pop;
   logic      head_valid;
   cmd_type   head_cmd;

   lhr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lhr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .fifo_full     (fifo_full),
      .push          (push),
      .push_cmd      (push_cmd),
      .sizes         (sizes)
   );

   lhr_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (fifo_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   lhr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .sizes          (sizes),
      .head_valid     (head_valid),
      .head_cmd       (head_cmd),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_error   (rsp_is_error),
      .rsp_run_last   (rsp_run_last),
      .rsp_stream_end (rsp_stream_end)
   );

endmodule
